// File: rtl/ps2ki_pkg.sv
package ps2ki_pkg;

    // Sequencer phases, one-hot coded.
    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_TXWAIT  = 8'b0000_0010,
        PH_ACKWAIT = 8'b0000_0100,
        PH_STWAIT  = 8'b0000_1000,
        PH_DELAY   = 8'b0001_0000,
        PH_SENDF0  = 8'b0010_0000,
        PH_SEND02  = 8'b0100_0000,
        PH_REPLY   = 8'b1000_0000
    } t_phase;

    // Command codes carried in the input beat.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_RXBYTE = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MAX_ATTEMPTS = 3'd0;
    localparam logic [2:0] CFG_TX_IDLE_LIMIT = 3'd1;
    localparam logic [2:0] CFG_ACK_WAIT     = 3'd2;
    localparam logic [2:0] CFG_SELFTEST_WAIT = 3'd3;
    localparam logic [2:0] CFG_RETRY_DELAY  = 3'd4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int WAIT_W     = 12;

    // Keyboard protocol bytes.
    localparam logic [7:0] BYTE_RESET = 8'hFF;
    localparam logic [7:0] BYTE_ACK   = 8'hFA;
    localparam logic [7:0] BYTE_BAT   = 8'hAA;
    localparam logic [7:0] BYTE_SET   = 8'hF0;
    localparam logic [7:0] BYTE_SET2  = 8'h02;

    // Register reset values.
    localparam logic [2:0]  RST_MAX_ATTEMPTS  = 3'd3;
    localparam logic [7:0]  RST_TX_IDLE_LIMIT = 8'd99;
    localparam logic [7:0]  RST_ACK_WAIT      = 8'd100;
    localparam logic [11:0] RST_SELFTEST_WAIT = 12'd1000;
    localparam logic [9:0]  RST_RETRY_DELAY   = 10'd100;

endpackage

// File: rtl/ps2_keyboard_init_sequencer.sv
// Host-side PS/2 keyboard bring-up sequencer. Each input beat is a command
// (start, one-millisecond tick, or received byte) plus the transmitter busy
// level; each accepted beat yields exactly one result beat telling whether a
// byte goes to the transmitter, whether the interface init pulse fires, and
// whether the sequence is running, has finished, and succeeded. A start
// resets the interface, sends 0xFF, expects 0xFA, waits for the 0xAA
// self-test byte, then sends 0xF0 0x02 and takes one reply byte. Timeouts and
// wrong bytes start a new attempt until max_attempts attempts have failed
// (a setting of zero allows one attempt); a wrong self-test byte first waits
// the retry delay. The block takes one beat per clock unless downstream stalls:
// the phase update is a single pass of logic between the state registers and
// the result register, so the result beat is presented the cycle after its
// input beat is accepted, and the result register accepts a new beat in the same
// cycle its current beat is taken downstream. The user must write configuration
// through the plain write port while no beat is in flight; the block does not check.
module ps2_keyboard_init_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [ps2ki_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [ps2ki_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // rx_byte[7:0], tx_busy[8], zero
    input  logic [1:0]                          s_axis_tuser,  // command[1:0]
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [15:0]                         m_axis_tdata,  // send_byte[7:0], init_pulse[8],
                                                               // running[9], done_res[10],
                                                               // success[11], zero
    output logic                                m_axis_tuser   // send_valid
);

    localparam int WW = ps2ki_pkg::WAIT_W;

    // Configuration registers.
    logic [2:0]  r_max_att;
    logic [7:0]  r_tx_lim;
    logic [7:0]  r_ack_lim;
    logic [11:0] r_st_lim;
    logic [9:0]  r_retry_lim;

    // Sequencer state.
    ps2ki_pkg::t_phase r_phase, n_phase;
    logic [2:0]    r_att, n_att;
    logic [WW-1:0] r_wait, n_wait;
    logic          r_pend_v, n_pend_v;
    logic [7:0]    r_pend_b, n_pend_b;

    // Result register.
    logic        r_out_valid;
    logic        r_send_v;
    logic [7:0]  r_send_b;
    logic        r_init, r_run, r_done, r_succ;

    // Per-beat combinational terms.
    logic          v_accept;
    logic [1:0]    v_cmd;
    logic [7:0]    v_rx;
    logic          v_busy;
    logic          v_tick;
    logic [WW-1:0] v_wait_inc;
    logic          v_fail;
    logic [2:0]    v_att_inc;
    logic          n_send_v, n_init, n_done, n_succ;
    logic [7:0]    n_send_b;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign v_accept      = s_axis_tvalid && s_axis_tready;
    assign v_cmd         = s_axis_tuser;
    assign v_rx          = s_axis_tdata[7:0];
    assign v_busy        = s_axis_tdata[8];
    assign v_tick        = (v_cmd == ps2ki_pkg::CMD_TICK);
    assign v_wait_inc    = r_wait + {{(WW-1){1'b0}}, 1'b1};
    assign v_att_inc     = r_att + 3'd1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_att   <= ps2ki_pkg::RST_MAX_ATTEMPTS;
            r_tx_lim    <= ps2ki_pkg::RST_TX_IDLE_LIMIT;
            r_ack_lim   <= ps2ki_pkg::RST_ACK_WAIT;
            r_st_lim    <= ps2ki_pkg::RST_SELFTEST_WAIT;
            r_retry_lim <= ps2ki_pkg::RST_RETRY_DELAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ps2ki_pkg::CFG_MAX_ATTEMPTS:  r_max_att   <= i_cfg_wdata[2:0];
                ps2ki_pkg::CFG_TX_IDLE_LIMIT: r_tx_lim    <= i_cfg_wdata[7:0];
                ps2ki_pkg::CFG_ACK_WAIT:      r_ack_lim   <= i_cfg_wdata[7:0];
                ps2ki_pkg::CFG_SELFTEST_WAIT: r_st_lim    <= i_cfg_wdata[11:0];
                ps2ki_pkg::CFG_RETRY_DELAY:   r_retry_lim <= i_cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // Phase evaluation for one beat.
    always_comb begin
        n_phase  = r_phase;
        n_att    = r_att;
        n_wait   = r_wait;
        n_pend_v = r_pend_v;
        n_pend_b = r_pend_b;
        n_send_v = 1'b0;
        n_send_b = 8'h00;
        n_init   = 1'b0;
        n_done   = 1'b0;
        n_succ   = 1'b0;
        v_fail   = 1'b0;

        if (v_cmd == ps2ki_pkg::CMD_START) begin
            n_pend_v = 1'b0;
            n_pend_b = 8'h00;
            n_att    = 3'd0;
            n_phase  = ps2ki_pkg::PH_TXWAIT;
            n_wait   = '0;
            n_init   = 1'b1;
        end else if (v_cmd == ps2ki_pkg::CMD_TICK || v_cmd == ps2ki_pkg::CMD_RXBYTE) begin
            // A received byte is latched before the phase looks at it.
            if (v_cmd == ps2ki_pkg::CMD_RXBYTE) begin
                n_pend_v = 1'b1;
                n_pend_b = v_rx;
            end
            unique case (r_phase)
                ps2ki_pkg::PH_TXWAIT: begin
                    if (!v_busy) begin
                        n_send_v = 1'b1;
                        n_send_b = ps2ki_pkg::BYTE_RESET;
                        n_phase  = ps2ki_pkg::PH_ACKWAIT;
                        n_wait   = '0;
                    end else if (v_tick) begin
                        n_wait = v_wait_inc;
                        v_fail = (v_wait_inc >= {4'd0, r_tx_lim});
                    end
                end
                ps2ki_pkg::PH_ACKWAIT: begin
                    if (n_pend_v) begin
                        n_pend_v = 1'b0;
                        if (n_pend_b == ps2ki_pkg::BYTE_ACK) begin
                            n_phase = ps2ki_pkg::PH_STWAIT;
                            n_wait  = '0;
                        end else begin
                            v_fail = 1'b1;
                        end
                    end else if (v_tick) begin
                        n_wait = v_wait_inc;
                        v_fail = (v_wait_inc >= {4'd0, r_ack_lim});
                    end
                end
                ps2ki_pkg::PH_STWAIT: begin
                    if (n_pend_v) begin
                        n_pend_v = 1'b0;
                        n_wait   = '0;
                        if (n_pend_b == ps2ki_pkg::BYTE_BAT) begin
                            n_phase = ps2ki_pkg::PH_SENDF0;
                        end else if (r_retry_lim == 10'd0) begin
                            v_fail = 1'b1;
                        end else begin
                            n_phase = ps2ki_pkg::PH_DELAY;
                        end
                    end else if (v_tick) begin
                        n_wait = v_wait_inc;
                        v_fail = (v_wait_inc >= r_st_lim);
                    end
                end
                ps2ki_pkg::PH_DELAY: begin
                    if (v_tick) begin
                        n_wait = v_wait_inc;
                        v_fail = (v_wait_inc >= {2'd0, r_retry_lim});
                    end
                end
                ps2ki_pkg::PH_SENDF0: begin
                    if (!v_busy) begin
                        n_send_v = 1'b1;
                        n_send_b = ps2ki_pkg::BYTE_SET;
                        n_phase  = ps2ki_pkg::PH_SEND02;
                    end
                end
                ps2ki_pkg::PH_SEND02: begin
                    if (!v_busy) begin
                        n_send_v = 1'b1;
                        n_send_b = ps2ki_pkg::BYTE_SET2;
                        n_phase  = ps2ki_pkg::PH_REPLY;
                    end
                end
                ps2ki_pkg::PH_REPLY: begin
                    if (n_pend_v) begin
                        n_pend_v = 1'b0;
                        n_phase  = ps2ki_pkg::PH_IDLE;
                        n_done   = 1'b1;
                        n_succ   = 1'b1;
                    end
                end
                default: ;
            endcase

            // A failed attempt either retries or ends the sequence.
            if (v_fail) begin
                n_att  = v_att_inc;
                n_wait = '0;
                if (v_att_inc >= r_max_att || v_att_inc == 3'd0) begin
                    n_phase = ps2ki_pkg::PH_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_phase = ps2ki_pkg::PH_TXWAIT;
                    n_init  = 1'b1;
                end
            end
        end
    end

    // State update on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ps2ki_pkg::PH_IDLE;
            r_att    <= 3'd0;
            r_wait   <= '0;
            r_pend_v <= 1'b0;
            r_pend_b <= 8'h00;
        end else if (v_accept) begin
            r_phase  <= n_phase;
            r_att    <= n_att;
            r_wait   <= n_wait;
            r_pend_v <= n_pend_v;
            r_pend_b <= n_pend_b;
        end
    end

    // Result register handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (v_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (v_accept) begin
            r_send_v <= n_send_v;
            r_send_b <= n_send_b;
            r_init   <= n_init;
            r_run    <= (n_phase != ps2ki_pkg::PH_IDLE);
            r_done   <= n_done;
            r_succ   <= n_succ;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_send_v;
    assign m_axis_tdata  = {4'd0, r_succ, r_done, r_run, r_init, r_send_b};

endmodule
